// ----- design/cstp_pkg.sv -----
// ----------------------------------------------------------------------------
// cstp_pkg: shared types for the call stack exclusive time profiler
// Status codes of a result item and the control bundle between the
// sequencer and the frame stack.
// ----------------------------------------------------------------------------
package cstp_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BAD_ID   = 3'd3,
    ST_BACKWARD = 3'd4
  } status_e;

  // one command group per cycle; at most one write to the child memory
  typedef struct packed {
    logic rd_top;     // read start and child time of the top frame
    logic rd_parent;  // read child time of the frame below the top
    logic push;       // push a new frame, child time zero
    logic pop;        // drop the top frame
    logic wr_parent;  // write child time of the frame below the top
  } stack_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic has_parent;
  } stack_flags_t;

endpackage

// ----- design/call_stack_exclusive_time_profiler_unit.sv -----
// ----------------------------------------------------------------------------
// call_stack_exclusive_time_profiler_unit: exclusive time per function id
// Tracks a bounded call stack of trace events and keeps a saturating
// exclusive-time total per function id.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one trace item: mode_i
//   (0 start, 1 end), function_id_i and timestamp_i. Output channel
//   (out_valid_o/out_ready_i) returns one result item per input item:
//   the id, its running exclusive total and a status code.
//   function_count is written through cfg_we_i/cfg_wdata_i while idle.
// Sequencing:
//   One item at a time; the next item is taken only after the result of
//   the last one is in the output register. Starts, rejected ids and error
//   cases go from the read state straight to output; a good end runs the
//   full read / compute / write-back sequence first. This follows from the
//   registered read ports of the stack and totals memories.
// Reset:
//   The stack empties at once; the totals memory is zeroed by a clearing
//   pass over min(MAX_FUNCTIONS, 256) entries during which in_ready_o is low.
// Backpressure:
//   A finished result sits in the output register; the sequencer takes and
//   works on the next item meanwhile and waits only to hand over its result.
// ----------------------------------------------------------------------------
module call_stack_exclusive_time_profiler_unit #(
  parameter int MAX_FUNCTIONS = 256,
  parameter int STACK_DEPTH   = 64,
  parameter int TIME_WIDTH    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  // trace items in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  function_id_i,
  input  logic [31:0] timestamp_i,
  // result items out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  result_id_o,
  output logic [31:0] exclusive_time_o,
  output logic [2:0]  status_o
);
  import cstp_pkg::*;

  // only ids below 256 can ever reach the table
  localparam int TOT_DEPTH = (MAX_FUNCTIONS < 256) ? MAX_FUNCTIONS : 256;
  localparam int TOT_AW    = (TOT_DEPTH > 1) ? $clog2(TOT_DEPTH) : 1;
  localparam int TW        = TIME_WIDTH;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  // configuration
  logic [8:0] fcount_q;

  // totals table and its clearing pass
  logic [TW-1:0]     tot_mem [TOT_DEPTH];
  logic [TW-1:0]     tot_rd_q;
  logic              clr_busy_q;
  logic [TOT_AW-1:0] clr_idx_q;

  // latched item
  logic              mode_q;
  logic [7:0]        id_q;
  logic [TW-1:0]     time_q;
  logic              id_ok_q;

  // work registers
  logic [TW:0]       dur_q, excl_q;
  logic [TW-1:0]     child_top_q;
  logic [TW-1:0]     total_q;
  status_e           status_q;

  // output register
  logic              out_valid_q;
  logic [7:0]        res_id_q;
  logic [31:0]       res_time_q;
  logic [2:0]        res_status_q;

  // stack interface
  stack_cmd_t        stk_cmd;
  stack_flags_t      stk_flags;
  logic [TW-1:0]     stk_start, stk_child;
  logic [TW-1:0]     parent_new;

  logic              in_fire;
  logic              id_ok;
  logic [63:0]       ts_ext;
  logic [TW-1:0]     ts_in;
  logic [TOT_AW-1:0] id_idx_in, id_idx_q;
  logic [TW+1:0]     tot_sum, child_sum;
  logic [TW-1:0]     tot_new;
  logic              out_free;
  logic [63:0]       total_ext;

  // --------------------------------------------------------------------------
  // item intake
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE) && !clr_busy_q;
  assign in_fire    = in_valid_i && in_ready_o;

  // only the low TIME_WIDTH bits of the timestamp count
  assign ts_ext = 64'(timestamp_i);
  assign ts_in  = ts_ext[TW-1:0];

  assign id_ok = ({5'b0, function_id_i} < 13'(MAX_FUNCTIONS))
              && ({1'b0, function_id_i} < fcount_q);

  assign id_idx_in = function_id_i[TOT_AW-1:0];
  assign id_idx_q  = id_q[TOT_AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcount_q <= 9'd256;
    end else if (cfg_we_i) begin
      fcount_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= mode_i;
      id_q    <= function_id_i;
      time_q  <= ts_in;
      id_ok_q <= id_ok;
    end
  end

  // --------------------------------------------------------------------------
  // saturating sums used at write-back
  // --------------------------------------------------------------------------
  assign tot_sum    = {2'b0, tot_rd_q} + {1'b0, excl_q};
  assign tot_new    = (|tot_sum[TW+1:TW]) ? {TW{1'b1}} : tot_sum[TW-1:0];
  assign child_sum  = {2'b0, stk_child} + {1'b0, dur_q};
  assign parent_new = (|child_sum[TW+1:TW]) ? {TW{1'b1}} : child_sum[TW-1:0];

  // --------------------------------------------------------------------------
  // totals memory: clear pass after reset, read on intake, write at WB
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + TOT_AW'(1);
      if (clr_idx_q == TOT_AW'(TOT_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      tot_mem[clr_idx_q] <= '0;
    end else if (state_q == S_WB) begin
      tot_mem[id_idx_q] <= tot_new;
    end
    if (in_fire) begin
      tot_rd_q <= tot_mem[id_idx_in];
    end
  end

  // --------------------------------------------------------------------------
  // frame stack
  // --------------------------------------------------------------------------
  cstp_frame_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .TIME_WIDTH  (TW)
  ) u_stack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (stk_cmd),
    .push_time_i    (time_q),
    .parent_child_i (parent_new),
    .flags_o        (stk_flags),
    .top_start_o    (stk_start),
    .child_rd_o     (stk_child)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    stk_cmd = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          stk_cmd.rd_top = 1'b1;
          state_d        = S_READ;
        end
      end
      S_READ: begin
        state_d = S_OUT;
        if (id_ok_q && !mode_q && !stk_flags.full) begin
          stk_cmd.push = 1'b1;
        end else if (id_ok_q && mode_q && !stk_flags.empty && (time_q >= stk_start)) begin
          stk_cmd.rd_parent = 1'b1;
          state_d           = S_CALC;
        end
      end
      S_CALC: begin
        state_d = S_WB;
      end
      S_WB: begin
        stk_cmd.pop       = 1'b1;
        stk_cmd.wr_parent = stk_flags.has_parent;
        state_d           = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // work registers per state
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_READ: begin
        dur_q       <= {1'b0, time_q} - {1'b0, stk_start} + (TW+1)'(1);
        child_top_q <= stk_child;
        if (!id_ok_q) begin
          status_q <= ST_BAD_ID;
          total_q  <= '0;
        end else begin
          total_q <= tot_rd_q;
          if (!mode_q && stk_flags.full) begin
            status_q <= ST_FULL;
          end else if (mode_q && stk_flags.empty) begin
            status_q <= ST_EMPTY;
          end else if (mode_q && (time_q < stk_start)) begin
            status_q <= ST_BACKWARD;
          end else begin
            status_q <= ST_OK;
          end
        end
      end
      S_CALC: begin
        // child time above the duration leaves nothing exclusive
        excl_q <= (dur_q > {1'b0, child_top_q}) ? (dur_q - {1'b0, child_top_q}) : '0;
      end
      S_WB: begin
        total_q <= tot_new;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  assign total_ext = 64'(total_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      res_id_q     <= id_q;
      res_time_q   <= total_ext[31:0];
      res_status_q <= status_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_id_o      = res_id_q;
  assign exclusive_time_o = res_time_q;
  assign status_o         = res_status_q;

endmodule

// ----- design/cstp_frame_stack.sv -----
// ----------------------------------------------------------------------------
// cstp_frame_stack: call stack of frames in two synchronous memories
// Start time and child time per frame, level counter, one registered
// read port per memory.
// ----------------------------------------------------------------------------
module cstp_frame_stack #(
  parameter int STACK_DEPTH = 64,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cstp_pkg::stack_cmd_t    cmd_i,
  input  logic [TIME_WIDTH-1:0]   push_time_i,
  input  logic [TIME_WIDTH-1:0]   parent_child_i,
  output cstp_pkg::stack_flags_t  flags_o,
  output logic [TIME_WIDTH-1:0]   top_start_o,
  output logic [TIME_WIDTH-1:0]   child_rd_o
);
  import cstp_pkg::*;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int LW  = $clog2(STACK_DEPTH + 1);

  logic [TIME_WIDTH-1:0] start_mem [STACK_DEPTH];
  logic [TIME_WIDTH-1:0] child_mem [STACK_DEPTH];

  logic [LW-1:0]  level_q, level_d;
  logic [LW-1:0]  top_lvl, parent_lvl;
  logic [SAW-1:0] push_addr, top_addr, parent_addr;

  assign top_lvl     = level_q - LW'(1);
  assign parent_lvl  = level_q - LW'(2);
  assign push_addr   = level_q[SAW-1:0];
  assign top_addr    = top_lvl[SAW-1:0];
  assign parent_addr = parent_lvl[SAW-1:0];

  assign flags_o.empty      = (level_q == '0);
  assign flags_o.full       = (level_q == LW'(STACK_DEPTH));
  assign flags_o.has_parent = (level_q >= LW'(2));

  always_comb begin
    level_d = level_q;
    if (cmd_i.push) begin
      level_d = level_q + LW'(1);
    end else if (cmd_i.pop) begin
      level_d = top_lvl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

  // frame contents: undefined until pushed
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      start_mem[push_addr] <= push_time_i;
    end
    if (cmd_i.rd_top) begin
      top_start_o <= start_mem[top_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      child_mem[push_addr] <= '0;
    end else if (cmd_i.wr_parent) begin
      child_mem[parent_addr] <= parent_child_i;
    end
    if (cmd_i.rd_top) begin
      child_rd_o <= child_mem[top_addr];
    end else if (cmd_i.rd_parent) begin
      child_rd_o <= child_mem[parent_addr];
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the call stack exclusive time profiler
// Drives start and end trace items through the valid/ready input channel,
// keeps its own copy of the call stack and the per-id totals, and checks
// every result item in order against that copy. Covers directed corner
// cases, id range settings, a full stack, and long random call sequences
// under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import cstp_pkg::*;

  localparam int NUM_IDS    = 256;
  localparam int STACK_SIZE = 64;
  localparam logic [31:0] TICKS_MAX = 32'hFFFF_FFFF;

  typedef struct {
    logic [7:0]  id;
    logic [31:0] total;
    status_e     status;
  } trace_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [8:0]  cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic        mode_i        = 1'b0;
  logic [7:0]  function_id_i = '0;
  logic [31:0] timestamp_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  result_id_o;
  logic [31:0] exclusive_time_o;
  logic [2:0]  status_o;

  always #5 clk_i = ~clk_i;

  call_stack_exclusive_time_profiler_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .function_id_i    (function_id_i),
    .timestamp_i      (timestamp_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_id_o      (result_id_o),
    .exclusive_time_o (exclusive_time_o),
    .status_o         (status_o)
  );

  // --------------------------------------------------------------------------
  // Shadow state of the profiler: function_count, call stack, totals.
  // --------------------------------------------------------------------------
  logic [8:0]  func_count;
  logic [7:0]  frame_fn    [STACK_SIZE];
  logic [31:0] frame_start [STACK_SIZE];
  logic [31:0] frame_child [STACK_SIZE];
  int          stack_lvl;
  logic [31:0] excl_totals [NUM_IDS];

  trace_result_t pending_results[$];  // predicted result items, oldest first
  int mismatch_count = 0;
  int send_idle_pct  = 0;             // chance per cycle the sender holds off
  int recv_stall_pct = 0;             // chance per cycle the receiver stalls
  logic [31:0] now_ticks = '0;        // trace clock of the random sequences

  // ids at or above this are rejected; zero rejects everything
  function automatic int unsigned id_limit();
    return (func_count > NUM_IDS) ? NUM_IDS : func_count;
  endfunction

  // saturating add; the addend may be a full 2^32 duration
  function automatic logic [31:0] add_sat(logic [31:0] a, logic [32:0] b);
    logic [33:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s > {2'b00, TICKS_MAX}) ? TICKS_MAX : s[31:0];
  endfunction

  // Apply one trace item to the shadow state and return its result item.
  function automatic trace_result_t profile_event(logic m, logic [7:0] id,
                                                  logic [31:0] ts);
    trace_result_t r;
    logic [32:0]   dur;
    logic [32:0]   excl;
    int            top;
    r.id     = id;
    r.total  = '0;
    r.status = ST_OK;
    if (id >= id_limit()) begin
      // range check comes first and leaves everything alone
      r.status = ST_BAD_ID;
    end else if (!m) begin
      if (stack_lvl >= STACK_SIZE) begin
        r.status = ST_FULL;
      end else begin
        frame_fn[stack_lvl]    = id;
        frame_start[stack_lvl] = ts;
        frame_child[stack_lvl] = '0;
        stack_lvl++;
      end
      r.total = excl_totals[id];
    end else begin
      if (stack_lvl == 0) begin
        r.status = ST_EMPTY;
      end else begin
        top = stack_lvl - 1;
        if (ts < frame_start[top]) begin
          r.status = ST_BACKWARD;
        end else begin
          // inclusive duration; the ending id is credited even if the
          // top frame belongs to another id
          dur  = {1'b0, ts} - {1'b0, frame_start[top]} + 33'd1;
          excl = (dur > {1'b0, frame_child[top]}) ?
                 dur - {1'b0, frame_child[top]} : '0;
          excl_totals[id] = add_sat(excl_totals[id], excl);
          stack_lvl = top;
          if (top > 0) frame_child[top-1] = add_sat(frame_child[top-1], dur);
        end
      end
      r.total = excl_totals[id];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls, in-order check against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    trace_result_t want;
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result item with none expected: id %0d time %0d status %0d",
                 $time, result_id_o, exclusive_time_o, status_o);
      end else begin
        want = pending_results.pop_front();
        if (result_id_o !== want.id) begin
          mismatch_count++;
          $display("%0t: result_id expected %0d actual %0d",
                   $time, want.id, result_id_o);
        end
        if (exclusive_time_o !== want.total) begin
          mismatch_count++;
          $display("%0t: exclusive_time (id %0d) expected %0d actual %0d",
                   $time, want.id, want.total, exclusive_time_o);
        end
        if (status_o !== want.status) begin
          mismatch_count++;
          $display("%0t: status (id %0d) expected %0d actual %0d",
                   $time, want.id, want.status, status_o);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Valid stays high across back-to-back items; it only drops in
  // an idle cycle or when the stream pauses.
  // --------------------------------------------------------------------------
  task automatic send_event(logic m, logic [7:0] id, logic [31:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    function_id_i <= id;
    timestamp_i   <= ts;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.insert(pending_results.size(), profile_event(m, id, ts));
  endtask

  // Pause the stream until every result item is back, then let the block settle.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Only called while idle.
  task automatic set_function_count(logic [8:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    func_count  = value;
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes and the special cases of the start/end bookkeeping.
  task automatic test_directed();
    send_event(1'b1, 8'd7,   32'd0);          // end on an empty stack
    send_event(1'b0, 8'd0,   32'd0);
    send_event(1'b0, 8'd255, 32'd5);
    send_event(1'b1, 8'd255, 32'd10);         // nested end, parent gets child time
    send_event(1'b1, 8'd0,   TICKS_MAX);      // 2^32 long outer frame
    send_event(1'b0, 8'd1,   32'd0);
    send_event(1'b1, 8'd1,   TICKS_MAX);      // total saturates
    send_event(1'b0, 8'd1,   32'd3);
    send_event(1'b1, 8'd1,   32'd9);          // stays saturated
    // child time larger than own duration: exclusive part is zero
    send_event(1'b0, 8'd2,   32'd1000);
    send_event(1'b0, 8'd3,   32'd0);
    send_event(1'b1, 8'd3,   32'd5000);
    send_event(1'b1, 8'd2,   32'd1500);
    // end before the frame's start, then an end with a different id
    send_event(1'b0, 8'd4,   32'd500);
    send_event(1'b1, 8'd4,   32'd499);
    send_event(1'b1, 8'd5,   32'd600);
    // crossed ids on a two-deep stack
    send_event(1'b0, 8'd6,   32'd100);
    send_event(1'b0, 8'd7,   32'd200);
    send_event(1'b1, 8'd6,   32'd300);
    send_event(1'b1, 8'd7,   32'd400);
    // child time saturates, parent still gets one tick
    send_event(1'b0, 8'd8,   32'd0);
    send_event(1'b0, 8'd9,   32'd0);
    send_event(1'b1, 8'd9,   TICKS_MAX);
    send_event(1'b1, 8'd8,   TICKS_MAX);
    wait_for_results();
  endtask

  // id range register: small, zero, one, above the table size, reset value.
  task automatic test_id_range();
    set_function_count(9'd10);
    send_event(1'b0, 8'd10,  32'd20);         // first rejected id
    send_event(1'b0, 8'd9,   32'd21);
    send_event(1'b1, 8'd9,   32'd30);
    send_event(1'b1, 8'd200, 32'd31);
    wait_for_results();
    set_function_count(9'd0);                 // every id rejected
    send_event(1'b0, 8'd0,   32'd40);
    send_event(1'b1, 8'd0,   32'd41);
    wait_for_results();
    set_function_count(9'd1);
    send_event(1'b0, 8'd0,   32'd50);
    send_event(1'b0, 8'd1,   32'd51);
    send_event(1'b1, 8'd0,   32'd60);
    wait_for_results();
    set_function_count(9'd511);               // clamps to the table size
    send_event(1'b0, 8'd255, 32'd70);
    send_event(1'b1, 8'd255, 32'd80);
    wait_for_results();
    set_function_count(9'd256);
  endtask

  // Fill the stack, push twice more, then unwind past the bottom.
  task automatic test_stack_full();
    while (stack_lvl < STACK_SIZE) begin
      now_ticks += $urandom_range(3);
      send_event(1'b0, 8'($urandom_range(NUM_IDS - 1)), now_ticks);
    end
    send_event(1'b0, 8'd17, now_ticks);
    send_event(1'b0, 8'd18, now_ticks + 32'd1);
    while (stack_lvl > 0) begin
      now_ticks += $urandom_range(3);
      send_event(1'b1, frame_fn[stack_lvl-1], now_ticks);
    end
    send_event(1'b1, 8'd19, now_ticks);
    wait_for_results();
  endtask

  // Mostly well-formed call sequences with random content, some noise.
  task automatic run_random(int n_items, int idle_pct, int stall_pct);
    int unsigned pick;
    int unsigned lim;
    logic [7:0]  id;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(199) == 0) wait_for_results();
      lim = id_limit();
      if ($urandom_range(99) < 8) begin
        send_event(1'($urandom_range(1)), 8'($urandom_range(255)), $urandom());
      end else begin
        pick = $urandom_range(99);
        if (pick < 80)      now_ticks += $urandom_range(15);
        else if (pick < 93) now_ticks += $urandom_range(5000);
        else if (pick < 97) now_ticks += 32'h4000_0000 + $urandom_range(1000);
        else                now_ticks -= $urandom_range(1, 100);
        if (stack_lvl == 0 || (stack_lvl < STACK_SIZE && $urandom_range(1) == 1)) begin
          if (lim == 0 || $urandom_range(19) == 0) id = 8'($urandom_range(255));
          else id = 8'($urandom_range(lim - 1));
          send_event(1'b0, id, now_ticks);
        end else begin
          if ($urandom_range(9) != 0) id = frame_fn[stack_lvl-1];
          else id = 8'($urandom_range(255));
          send_event(1'b1, id, now_ticks);
        end
      end
    end
    wait_for_results();
  endtask

  // Four idling mixes, each under its own function_count setting.
  task automatic test_random();
    run_random(500, 0, 0);
    set_function_count(9'd200);
    run_random(500, 52, 0);
    set_function_count(9'd511);
    run_random(500, 0, 52);
    set_function_count(9'd64);
    run_random(500, 22, 22);
    set_function_count(9'd256);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // shadow state after reset
    func_count = 9'd256;
    stack_lvl  = 0;
    for (int i = 0; i < NUM_IDS; i++) excl_totals[i] = '0;
    for (int i = 0; i < STACK_SIZE; i++) begin
      frame_fn[i]    = '0;
      frame_start[i] = '0;
      frame_child[i] = '0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // the clearing pass after reset holds in_ready low; send_event waits
    test_directed();
    test_id_range();
    test_stack_full();
    test_random();

    wait_for_results();
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
